[hw/rtl/rgb_to_hsv_converter_macros.svh]
// assertion macros for the checker file of the rgb to hsv converter
// no dependencies; take it in with an include of the bare file name
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// clocked assertion, masked while reset is held
`define RHC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define RHC_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rhc_pkg.sv]
// shared widths and codes for the rgb to hsv converter
// no dependencies; imported by every module of the block
package rhc_pkg;

    // channel and result widths
    localparam int unsigned CH_W   = 8;
    localparam int unsigned HUE_W  = 16;
    localparam int unsigned SAT_W  = 16;
    localparam int unsigned QUOT_W = 16;

    // six times chroma fits in three more bits than a channel
    localparam int unsigned SIX_W  = CH_W + 3;

    // saturation dividend is chroma * 65535, up to channel + quotient bits
    localparam int unsigned SNUM_W = CH_W + QUOT_W;

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_max_sel;

endpackage

[hw/rtl/rhc_frac_div.sv]
// pipelined restoring divider, one quotient bit per register stage
// depends on rhc_pkg for the default quotient width
module rhc_frac_div
    import rhc_pkg::*;
#(
    parameter int unsigned DEN_W = CH_W,
    parameter int unsigned Q_W   = QUOT_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [DEN_W-1:0] i_den,
    input  logic [Q_W-1:0]   i_low,
    output logic [Q_W-1:0]   o_quot
);

    // stage registers
    logic [DEN_W-1:0] r_rem  [Q_W];
    logic [DEN_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];
    logic [Q_W-1:0]   r_low  [Q_W-1];

    // stage inputs, entry zero comes from the ports
    logic [DEN_W-1:0] s_rem  [Q_W+1];
    logic [DEN_W-1:0] s_den  [Q_W+1];
    logic [Q_W-1:0]   s_quot [Q_W+1];
    logic [Q_W-1:0]   s_low  [Q_W];

    assign s_rem[0]  = i_rem;
    assign s_den[0]  = i_den;
    assign s_quot[0] = '0;
    assign s_low[0]  = i_low;

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic [DEN_W:0]   t_trial;
            logic [DEN_W:0]   t_diff;
            logic             t_ge;
            logic [DEN_W-1:0] n_rem;
            logic [Q_W-1:0]   n_quot;

            // shift in the next dividend bit and try a subtract
            assign t_trial = {s_rem[k], s_low[k][Q_W-1]};
            assign t_diff  = t_trial - {1'b0, s_den[k]};
            assign t_ge    = (t_trial >= {1'b0, s_den[k]});
            assign n_rem   = t_ge ? t_diff[DEN_W-1:0] : t_trial[DEN_W-1:0];
            assign n_quot  = {s_quot[k][Q_W-2:0], t_ge};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_den[k]  <= s_den[k];
                    r_quot[k] <= n_quot;
                end
            end

            assign s_rem[k+1]  = r_rem[k];
            assign s_den[k+1]  = r_den[k];
            assign s_quot[k+1] = r_quot[k];

            // remaining dividend bits travel one stage behind each other
            if (k < Q_W - 1) begin : g_low
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_low[k] <= {s_low[k][Q_W-2:0], 1'b0};
                    end
                end
                assign s_low[k+1] = r_low[k];
            end
        end
    endgenerate

    assign o_quot = s_quot[Q_W];

endmodule

[hw/rtl/rgb_to_hsv_converter.sv]
// top level of the rgb to hsv converter: front end, two divider pipes, output skid
// depends on rhc_pkg and rhc_frac_div
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  pixel   | i_in_valid / o_in_ready    | i_red, i_green, i_blue (8 bit each)
//  hsv     | o_out_valid / i_out_ready  | o_hue (16), o_saturation (16), o_brightness (8)
//
// one pixel per clock sustained while the output keeps taking items; from acceptance to
// o_out_valid an item passes two front-end stages, sixteen divider stages and one output register
// the depth is set by the two dividers, one quotient bit per stage
// reset clears only valid bits and the skid flag; payload registers are not reset
// a stall at the output parks one item in the skid register and freezes the pipe,
// o_in_ready is a register output and falls only while the skid register is full
module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CH_W-1:0]   i_red,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_blue,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [HUE_W-1:0]  o_hue,
    output logic [SAT_W-1:0]  o_saturation,
    output logic [CH_W-1:0]   o_brightness
);

    logic pipe_en;

    // ------------------------------------------------------------------
    // stage 1: maximum, minimum and chroma
    // ------------------------------------------------------------------
    t_max_sel        n1_sel;
    logic [CH_W-1:0] n1_top;
    logic [CH_W-1:0] n1_bottom;

    logic            r1_vld;
    t_max_sel        r1_sel;
    logic [CH_W-1:0] r1_red;
    logic [CH_W-1:0] r1_green;
    logic [CH_W-1:0] r1_blue;
    logic [CH_W-1:0] r1_top;
    logic [CH_W-1:0] r1_chroma;

    // ties go to red, then green
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n1_sel = SEL_RED;
            n1_top = i_red;
        end else if (i_green >= i_blue) begin
            n1_sel = SEL_GREEN;
            n1_top = i_green;
        end else begin
            n1_sel = SEL_BLUE;
            n1_top = i_blue;
        end
        if (i_red <= i_green) begin
            n1_bottom = (i_red <= i_blue) ? i_red : i_blue;
        end else begin
            n1_bottom = (i_green <= i_blue) ? i_green : i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (pipe_en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_sel    <= n1_sel;
            r1_red    <= i_red;
            r1_green  <= i_green;
            r1_blue   <= i_blue;
            r1_top    <= n1_top;
            r1_chroma <= n1_top - n1_bottom;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: hue numerator, six chroma and saturation dividend
    // ------------------------------------------------------------------
    logic [SIX_W-1:0]  ext_r;
    logic [SIX_W-1:0]  ext_g;
    logic [SIX_W-1:0]  ext_b;
    logic [SIX_W-1:0]  ext_c;
    logic [SIX_W-1:0]  n2_six_c;
    logic [SIX_W-1:0]  n2_hnum;
    logic [SNUM_W-1:0] n2_snum;

    logic              r2_vld;
    logic              r2_zero;
    logic [CH_W-1:0]   r2_top;
    logic [SIX_W-1:0]  r2_six_c;
    logic [SIX_W-1:0]  r2_hnum;
    logic [SNUM_W-1:0] r2_snum;

    assign ext_r    = SIX_W'(r1_red);
    assign ext_g    = SIX_W'(r1_green);
    assign ext_b    = SIX_W'(r1_blue);
    assign ext_c    = SIX_W'(r1_chroma);
    assign n2_six_c = (ext_c << 2) + (ext_c << 1);

    // chroma * 65535 as a shift and a subtract
    assign n2_snum  = {r1_chroma, {QUOT_W{1'b0}}} - SNUM_W'(r1_chroma);

    // numerator below six chroma; a negative red sector wraps by one turn
    always_comb begin
        case (r1_sel)
            SEL_RED: begin
                if (r1_green >= r1_blue) begin
                    n2_hnum = ext_g - ext_b;
                end else begin
                    n2_hnum = n2_six_c - (ext_b - ext_g);
                end
            end
            SEL_GREEN: n2_hnum = ext_b + (ext_c << 1) - ext_r;
            SEL_BLUE:  n2_hnum = ext_r + (ext_c << 2) - ext_g;
            default:   n2_hnum = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (pipe_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_zero  <= (r1_chroma == '0);
            r2_top   <= r1_top;
            r2_six_c <= n2_six_c;
            r2_hnum  <= n2_hnum;
            r2_snum  <= n2_snum;
        end
    end

    // ------------------------------------------------------------------
    // divider pipes: hue = hnum * 65536 / 6C, sat = C * 65535 / max
    // ------------------------------------------------------------------
    logic [QUOT_W-1:0] hue_quot;
    logic [QUOT_W-1:0] sat_quot;

    rhc_frac_div #(
        .DEN_W (SIX_W),
        .Q_W   (QUOT_W)
    ) u_hue_div (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_rem  (r2_hnum),
        .i_den  (r2_six_c),
        .i_low  ({QUOT_W{1'b0}}),
        .o_quot (hue_quot)
    );

    rhc_frac_div #(
        .DEN_W (CH_W),
        .Q_W   (QUOT_W)
    ) u_sat_div (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_rem  (r2_snum[SNUM_W-1:QUOT_W]),
        .i_den  (r2_top),
        .i_low  (r2_snum[QUOT_W-1:0]),
        .o_quot (sat_quot)
    );

    // side band that keeps pace with the divider stages
    logic            r_vld_d  [QUOT_W];
    logic            r_zero_d [QUOT_W];
    logic [CH_W-1:0] r_top_d  [QUOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QUOT_W; s++) begin
                r_vld_d[s] <= 1'b0;
            end
        end else if (pipe_en) begin
            r_vld_d[0] <= r2_vld;
            for (int s = 1; s < QUOT_W; s++) begin
                r_vld_d[s] <= r_vld_d[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_zero_d[0] <= r2_zero;
            r_top_d[0]  <= r2_top;
            for (int s = 1; s < QUOT_W; s++) begin
                r_zero_d[s] <= r_zero_d[s-1];
                r_top_d[s]  <= r_top_d[s-1];
            end
        end
    end

    // gray pixels force hue and saturation to zero
    logic              tail_vld;
    logic [HUE_W-1:0]  tail_hue;
    logic [SAT_W-1:0]  tail_sat;
    logic [CH_W-1:0]   tail_top;

    assign tail_vld = r_vld_d[QUOT_W-1];
    assign tail_hue = r_zero_d[QUOT_W-1] ? '0 : HUE_W'(hue_quot);
    assign tail_sat = r_zero_d[QUOT_W-1] ? '0 : SAT_W'(sat_quot);
    assign tail_top = r_top_d[QUOT_W-1];

    // ------------------------------------------------------------------
    // output register with one skid entry
    // ------------------------------------------------------------------
    logic              r_out_vld;
    logic [HUE_W-1:0]  r_out_hue;
    logic [SAT_W-1:0]  r_out_sat;
    logic [CH_W-1:0]   r_out_top;
    logic              r_skid_vld;
    logic [HUE_W-1:0]  r_skid_hue;
    logic [SAT_W-1:0]  r_skid_sat;
    logic [CH_W-1:0]   r_skid_top;
    logic              out_free;
    logic              tail_take;

    assign pipe_en   = !r_skid_vld;
    assign out_free  = !r_out_vld || i_out_ready;
    assign tail_take = pipe_en && tail_vld;

    // control: out register refills from skid first, else from the pipe tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld  <= r_skid_vld || tail_take;
            r_skid_vld <= 1'b0;
        end else if (tail_take) begin
            r_skid_vld <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out_hue <= r_skid_hue;
                r_out_sat <= r_skid_sat;
                r_out_top <= r_skid_top;
            end else begin
                r_out_hue <= tail_hue;
                r_out_sat <= tail_sat;
                r_out_top <= tail_top;
            end
        end else if (tail_take) begin
            r_skid_hue <= tail_hue;
            r_skid_sat <= tail_sat;
            r_skid_top <= tail_top;
        end
    end

    assign o_in_ready   = pipe_en;
    assign o_out_valid  = r_out_vld;
    assign o_hue        = r_out_hue;
    assign o_saturation = r_out_sat;
    assign o_brightness = r_out_top;

endmodule

[hw/rtl/rhc_checker.sv]
// port-level checks for the rgb to hsv converter, bound to the top level
// depends on rhc_pkg and rgb_to_hsv_converter_macros.svh
`include "rgb_to_hsv_converter_macros.svh"

module rhc_checker
    import rhc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [HUE_W-1:0] o_hue,
    input logic [SAT_W-1:0] o_saturation,
    input logic [CH_W-1:0]  o_brightness
);

    // a stalled item holds its value
    `RHC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hue) && $stable(o_saturation) && $stable(o_brightness), "stalled item changed")

    // input side stalls only while an item waits at the output
    `RHC_ASSERT_RST(a_ready_low, i_clk, i_rst_n, !o_in_ready |-> o_out_valid, "input stalled with empty output")

    // zero saturation means gray, and gray has zero hue
    `RHC_ASSERT_RST(a_gray_hue, i_clk, i_rst_n, o_out_valid && o_saturation == '0 |-> o_hue == '0, "gray item with nonzero hue")

    // black has neither hue nor saturation
    `RHC_ASSERT_RST(a_black, i_clk, i_rst_n, o_out_valid && o_brightness == '0 |-> o_saturation == '0 && o_hue == '0, "black item with color")

    // reset empties the pipe and frees the input
    `RHC_ASSERT_ALL(a_reset, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready, "reset left an item")

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hue        (o_hue),
    .o_saturation (o_saturation),
    .o_brightness (o_brightness)
);

[verif/tb.sv]
// self-checking testbench for the rgb to hsv converter, top module tb
// depends on rhc_pkg and the converter rtl; predicts hue, saturation and value per pixel
`timescale 1ns / 100ps

module tb;
    import rhc_pkg::*;

    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned PIPE_DEPTH   = 19;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;

    // pixel together with the hsv it should turn into
    typedef struct {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [CH_W-1:0]  bright;
    } t_pixel_hsv;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic [CH_W-1:0]   i_red        = '0;
    logic [CH_W-1:0]   i_green      = '0;
    logic [CH_W-1:0]   i_blue       = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [HUE_W-1:0]  o_hue;
    logic [SAT_W-1:0]  o_saturation;
    logic [CH_W-1:0]   o_brightness;

    t_pixel_hsv  pending_hsv[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 22;
    int unsigned recv_idle_pct  = 57;
    int unsigned hold_req_cnt   = 0;
    int unsigned hold_ack_cnt   = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    rgb_to_hsv_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hue, saturation and value of one pixel in exact integer ratios
    function automatic t_pixel_hsv hsv_of_pixel(input logic [CH_W-1:0] r,
                                                input logic [CH_W-1:0] g,
                                                input logic [CH_W-1:0] b);
        t_pixel_hsv  res;
        t_max_sel    sel;
        int unsigned ri;
        int unsigned gi;
        int unsigned bi;
        int unsigned top;
        int unsigned bottom;
        int unsigned chroma;
        int unsigned six_c;
        int unsigned num;
        res.red    = r;
        res.green  = g;
        res.blue   = b;
        ri     = 32'(r);
        gi     = 32'(g);
        bi     = 32'(b);
        top    = ri;
        bottom = ri;
        if (gi > top) top = gi;
        if (bi > top) top = bi;
        if (gi < bottom) bottom = gi;
        if (bi < bottom) bottom = bi;
        chroma = top - bottom;
        // ties go to red first, then green
        if (top == ri) sel = SEL_RED;
        else if (top == gi) sel = SEL_GREEN;
        else sel = SEL_BLUE;
        res.hue    = '0;
        res.sat    = '0;
        res.bright = top[CH_W-1:0];
        // gray pixels keep zero hue and saturation
        if (chroma != 0) begin
            six_c = 6 * chroma;
            res.sat = SAT_W'((chroma * 65535) / top);
            case (sel)
                SEL_RED: begin
                    // negative hue wraps by one full turn
                    if (gi >= bi) num = gi - bi;
                    else num = six_c - (bi - gi);
                end
                SEL_GREEN: num = bi + 2 * chroma - ri;
                default:   num = ri + 4 * chroma - gi;
            endcase
            res.hue = HUE_W'((num * 65536) / six_c);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // offer one pixel, keep it steady until taken
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_hsv.push_back(hsv_of_pixel(r, g, b));
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_hsv.size() != 0) @(posedge i_clk);
    endtask

    // draw a pixel, weighted toward ties, grays and edge values
    task automatic pick_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
                              output logic [CH_W-1:0] b);
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        int unsigned     kind;
        kind = $urandom_range(0, 9);
        r = CH_W'($urandom_range(0, 255));
        g = CH_W'($urandom_range(0, 255));
        b = CH_W'($urandom_range(0, 255));
        case (kind)
            5: begin
                g = r;
                b = r;
            end
            6: begin
                hi = CH_W'($urandom_range(1, 255));
                lo = CH_W'($urandom_range(0, 32'(hi)));
                case ($urandom_range(0, 2))
                    0: begin r = hi; g = hi; b = lo; end
                    1: begin r = hi; g = lo; b = hi; end
                    default: begin r = lo; g = hi; b = hi; end
                endcase
            end
            7: begin
                r = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ CH_W'($urandom_range(0, 1));
                g = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ CH_W'($urandom_range(0, 1));
                b = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ CH_W'($urandom_range(0, 1));
            end
            8: begin
                // chroma of at most one
                lo = CH_W'($urandom_range(0, 254));
                r = lo + CH_W'($urandom_range(0, 1));
                g = lo + CH_W'($urandom_range(0, 1));
                b = lo + CH_W'($urandom_range(0, 1));
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    1: g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default: b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                endcase
            end
            default: ;
        endcase
    endtask

    // primaries, ties, grays, wrap of negative hue, unit chroma
    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd1);
        send_pixel(8'd1,   8'd255, 8'd0);
        send_pixel(8'd1,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd255, 8'd254, 8'd0);
        stop_sending();
        wait_drain();
    endtask

    task automatic test_random(input int unsigned n_items, input int unsigned s_pct,
                               input int unsigned r_pct);
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        repeat (n_items) begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        stop_sending();
        wait_drain();
    endtask

    // long output stall while pixels keep coming, so the input backs up
    task automatic test_backpressure();
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req_cnt  <= hold_req_cnt + 1;
        repeat (60) begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        stop_sending();
        wait_drain();
    endtask

    // result check and output ready
    always @(posedge i_clk) begin
        t_pixel_hsv want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_hsv.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: h=%0d s=%0d v=%0d",
                                          o_hue, o_saturation, o_brightness));
            end else begin
                want = pending_hsv.pop_front();
                if (o_hue !== want.hue)
                    report_mismatch($sformatf("rgb %0d,%0d,%0d hue got %0d want %0d",
                                    want.red, want.green, want.blue, o_hue, want.hue));
                if (o_saturation !== want.sat)
                    report_mismatch($sformatf("rgb %0d,%0d,%0d sat got %0d want %0d",
                                    want.red, want.green, want.blue, o_saturation, want.sat));
                if (o_brightness !== want.bright)
                    report_mismatch($sformatf("rgb %0d,%0d,%0d val got %0d want %0d",
                                    want.red, want.green, want.blue, o_brightness,
                                    want.bright));
            end
        end
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[rgb_to_hsv_converter] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(190, 22, 57);
        test_random(190, 57, 22);
        test_random(190, 0, 0);
        test_backpressure();
        wait_drain();
        repeat (PIPE_DEPTH + 6) @(posedge i_clk);
        if (mismatch_count == 0 && pending_hsv.size() == 0) begin
            $display("[rgb_to_hsv_converter] OK");
        end else begin
            $display("[rgb_to_hsv_converter] ERROR");
        end
        $finish;
    end

endmodule
